@@ src/page_marker_record_walker_defines.svh @@
// Assertion macros shared by the page marker record walker checkers.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef PAGE_MARKER_RECORD_WALKER_DEFINES_SVH
`define PAGE_MARKER_RECORD_WALKER_DEFINES_SVH

// Same-cycle implication.
`define PMRW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PMRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pmrw_pkg.sv @@
// Shared types and constants for the page marker record walker.
// No dependencies; imported by every module of the block but pmrw_fifo.
`timescale 1ns / 1ps

package pmrw_pkg;

  localparam int unsigned MaxSlotW = 9;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] RegPageKind    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTagFilter   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSubTagFilter = 2'd2;

  localparam logic [7:0]  TagLo       = 8'hC0;
  localparam logic [7:0]  TagHi       = 8'hCF;
  localparam logic [7:0]  LeafTag     = 8'hC3;
  localparam logic [7:0]  InternalTag = 8'hC2;
  localparam logic [7:0]  AltTreeTag  = 8'hD2;
  localparam logic [7:0]  WildFilter  = 8'hFF;
  localparam logic [31:0] MarkerMagic = 32'h0000_0001;

  typedef enum logic [1:0] {
    KindLeaf     = 2'd0,
    KindInternal = 2'd1,
    KindTree     = 2'd2,
    KindAny      = 2'd3
  } kind_mode_e;

  typedef struct packed {
    logic [7:0] tag;
    logic [7:0] sub_tag;
  } filter_t;

  typedef struct packed {
    logic                marker;
    logic                final_slot;
    logic [MaxSlotW-1:0] slot;
    logic [7:0]          tag;
    logic [7:0]          sub_tag;
    logic [15:0]         flags;
    logic [15:0]         page_num;
  } slot_op_t;

  typedef struct packed {
    logic [15:0] page_num;
    logic [7:0]  tag;
    logic [7:0]  sub_tag;
    logic [15:0] flags;
    logic [7:0]  mark_pos;
    logic [8:0]  body_pos;
    logic [7:0]  body_len;
    logic        last;
  } record_t;

endpackage

@@ src/pmrw_front.sv @@
// Front end: accepts slot words, tracks slot and page position, checks page kind
// and marker pattern, and pushes marker and page-end events. Uses pmrw_pkg.
`timescale 1ns / 1ps

module pmrw_front import pmrw_pkg::*; #(
  parameter int unsigned PAGE_BYTES       = 256,
  parameter int unsigned PAGE_INDEX_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] slot_bytes_i,
  input  kind_mode_e  mode_i,
  output logic        op_valid_o,
  output slot_op_t    op_o,
  input  logic        op_ready_i
);

  localparam int unsigned Slots = PAGE_BYTES / 8;
  localparam int unsigned SlotW = $clog2(Slots);

  logic [SlotW-1:0]            slot_q, slot_d;
  logic                        page_ok_q, page_ok_d;
  logic [PAGE_INDEX_WIDTH-1:0] page_cnt_q, page_cnt_d;

  logic [7:0] b0;
  logic       kind_ok, ok, is_marker, last_slot, accept;

  assign b0 = slot_bytes_i[63:56];

  always_comb begin
    case (mode_i)
      KindLeaf:     kind_ok = (b0 == LeafTag);
      KindInternal: kind_ok = (b0 == InternalTag);
      KindTree:     kind_ok = (b0 inside {[TagLo:TagHi]}) || (b0 == AltTreeTag);
      default:      kind_ok = 1'b1;
    endcase
  end

  assign is_marker = (b0 inside {[TagLo:TagHi]}) && (slot_bytes_i[47:16] == MarkerMagic);
  assign ok        = (slot_q == '0) ? kind_ok : page_ok_q;
  assign last_slot = (slot_q == SlotW'(Slots - 1));
  assign accept    = in_valid_i && op_ready_i;

  assign in_ready_o = op_ready_i;
  assign op_valid_o = accept && ((ok && is_marker) || last_slot);

  always_comb begin
    op_o.marker     = ok && is_marker;
    op_o.final_slot = last_slot;
    op_o.slot       = MaxSlotW'(slot_q);
    op_o.tag        = b0;
    op_o.sub_tag    = slot_bytes_i[55:48];
    op_o.flags      = slot_bytes_i[15:0];
    op_o.page_num   = 16'(page_cnt_q);
  end

  always_comb begin
    slot_d     = slot_q;
    page_ok_d  = page_ok_q;
    page_cnt_d = page_cnt_q;
    if (accept) begin
      if (last_slot) begin
        slot_d     = '0;
        page_ok_d  = 1'b0;
        page_cnt_d = page_cnt_q + 1'b1;
      end else begin
        slot_d    = slot_q + 1'b1;
        page_ok_d = ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      page_ok_q  <= 1'b0;
      page_cnt_q <= '0;
    end else begin
      slot_q     <= slot_d;
      page_ok_q  <= page_ok_d;
      page_cnt_q <= page_cnt_d;
    end
  end

endmodule

@@ src/pmrw_fifo.sv @@
// Small register queue between front and back end.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps

module pmrw_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ src/pmrw_back.sv @@
// Back end: holds the open record, closes it on the next marker or page end,
// applies tag filters and drives the registered output word. Uses pmrw_pkg.
`timescale 1ns / 1ps

module pmrw_back import pmrw_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     op_valid_i,
  output logic     op_ready_o,
  input  slot_op_t op_i,
  input  filter_t  filt_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output record_t  rec_o
);

  localparam int unsigned Slots = PAGE_BYTES / 8;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned OffW  = (SlotW + 4 > 10) ? SlotW + 4 : 10;

  logic             pv_q;
  logic [7:0]       ptag_q, psub_q;
  logic [15:0]      pflags_q;
  logic [SlotW-1:0] pslot_q;
  logic             phase_q;
  logic             out_valid_q;
  record_t          rec_q;

  logic [SlotW-1:0] new_slot, slot1;
  logic [OffW-1:0]  moff0, poff0, end0, size0, moff1, poff1, end1, size1;
  logic             pass_pend, pass_new, e0, e1, sel1, emit, out_free, step, pop;
  record_t          rec0, rec1;

  assign new_slot = op_i.slot[SlotW-1:0];
  assign slot1    = op_i.marker ? new_slot : pslot_q;

  assign pass_pend = ((filt_i.tag == WildFilter) || (ptag_q == filt_i.tag)) &&
                     ((filt_i.sub_tag == WildFilter) || (psub_q == filt_i.sub_tag));
  assign pass_new  = ((filt_i.tag == WildFilter) || (op_i.tag == filt_i.tag)) &&
                     ((filt_i.sub_tag == WildFilter) || (op_i.sub_tag == filt_i.sub_tag));

  assign e0 = op_i.marker && pv_q && pass_pend;
  assign e1 = op_i.final_slot && (op_i.marker ? pass_new : (pv_q && pass_pend));

  assign moff0 = OffW'(pslot_q) << 3;
  assign poff0 = moff0 + OffW'(8);
  assign end0  = OffW'(new_slot) << 3;
  assign size0 = (end0 >= poff0) ? end0 - poff0 : '0;

  assign moff1 = OffW'(slot1) << 3;
  assign poff1 = moff1 + OffW'(8);
  assign end1  = OffW'(PAGE_BYTES);
  assign size1 = (end1 >= poff1) ? end1 - poff1 : '0;

  always_comb begin
    rec0.page_num = op_i.page_num;
    rec0.tag      = ptag_q;
    rec0.sub_tag  = psub_q;
    rec0.flags    = pflags_q;
    rec0.mark_pos = moff0[7:0];
    rec0.body_pos = poff0[8:0];
    rec0.body_len = size0[7:0];
    rec0.last     = op_i.final_slot && !e1;

    rec1.page_num = op_i.page_num;
    rec1.tag      = op_i.marker ? op_i.tag : ptag_q;
    rec1.sub_tag  = op_i.marker ? op_i.sub_tag : psub_q;
    rec1.flags    = op_i.marker ? op_i.flags : pflags_q;
    rec1.mark_pos = moff1[7:0];
    rec1.body_pos = poff1[8:0];
    rec1.body_len = size1[7:0];
    rec1.last     = 1'b1;
  end

  assign sel1     = phase_q || !e0;
  assign emit     = sel1 ? e1 : 1'b1;
  assign out_free = !out_valid_q || out_ready_i;
  assign step     = op_valid_i && (!emit || out_free);
  assign pop      = step && (sel1 || !e1);

  assign op_ready_o  = pop;
  assign out_valid_o = out_valid_q;
  assign rec_o       = rec_q;

  always_ff @(posedge clk_i) begin
    if (step && emit && out_free) begin
      rec_q <= sel1 ? rec1 : rec0;
    end
    if (pop && op_i.marker) begin
      ptag_q   <= op_i.tag;
      psub_q   <= op_i.sub_tag;
      pflags_q <= op_i.flags;
      pslot_q  <= new_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q        <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        phase_q <= 1'b0;
      end else if (step) begin
        phase_q <= 1'b1;
      end
      if (pop) begin
        if (op_i.final_slot) begin
          pv_q <= 1'b0;
        end else if (op_i.marker) begin
          pv_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/page_marker_record_walker.sv @@
// Top level of the page marker record walker: configuration registers,
// front end, event queue and back end. Uses pmrw_pkg and the pmrw_* modules.
//
//   channel | signals                          | direction
//   in      | in_valid_i/in_ready_o, slot word | slot words of a page, slot 0 first
//   out     | out_valid_o/out_ready_i, record  | one record per word
//   cfg     | cfg_valid_i/cfg_ready_o, idx+data| register writes, always ready
//
// One slot word per cycle while the queue has room. A page-end slot that
// closes two records yields two words; the two-entry event queue absorbs it.
// Events pass the event queue; records leave by the registered output word.
// Reset clears position, page count and the open record; no clearing pass.
// A stalled output holds its word; the queue takes slots until it fills.
`timescale 1ns / 1ps

module page_marker_record_walker import pmrw_pkg::*; #(
  parameter int unsigned PAGE_BYTES       = 256,
  parameter int unsigned PAGE_INDEX_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        slot_bytes_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        page_number_o,
  output logic [7:0]         record_tag_o,
  output logic [7:0]         record_sub_tag_o,
  output logic [15:0]        record_flags_o,
  output logic [7:0]         marker_offset_o,
  output logic [8:0]         payload_offset_o,
  output logic [7:0]         payload_size_o,
  output logic               last_of_page_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned QueueDepth = 2;

  kind_mode_e mode_q;
  filter_t    filt_q;

  logic     push_valid, push_ready, head_valid, head_ready;
  slot_op_t push_op, head_op;
  record_t  rec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= KindAny;
      filt_q.tag     <= WildFilter;
      filt_q.sub_tag <= WildFilter;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPageKind:     mode_q         <= kind_mode_e'(cfg_data_i[1:0]);
        RegTagFilter:    filt_q.tag     <= cfg_data_i;
        RegSubTagFilter: filt_q.sub_tag <= cfg_data_i;
        default:         mode_q         <= mode_q;
      endcase
    end
  end

  pmrw_front #(
    .PAGE_BYTES      (PAGE_BYTES),
    .PAGE_INDEX_WIDTH(PAGE_INDEX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .slot_bytes_i(slot_bytes_i),
    .mode_i      (mode_q),
    .op_valid_o  (push_valid),
    .op_o        (push_op),
    .op_ready_i  (push_ready)
  );

  pmrw_fifo #(
    .Width($bits(slot_op_t)),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push_valid),
    .wr_ready_o(push_ready),
    .wr_data_i (push_op),
    .rd_valid_o(head_valid),
    .rd_ready_i(head_ready),
    .rd_data_o (head_op)
  );

  pmrw_back #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (head_valid),
    .op_ready_o (head_ready),
    .op_i       (head_op),
    .filt_i     (filt_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .rec_o      (rec)
  );

  assign page_number_o    = rec.page_num;
  assign record_tag_o     = rec.tag;
  assign record_sub_tag_o = rec.sub_tag;
  assign record_flags_o   = rec.flags;
  assign marker_offset_o  = rec.mark_pos;
  assign payload_offset_o = rec.body_pos;
  assign payload_size_o   = rec.body_len;
  assign last_of_page_o   = rec.last;

endmodule

@@ src/pmrw_checker.sv @@
// Port-level checks for the page marker record walker, bound to the top level.
// Uses pmrw_pkg and the macros in page_marker_record_walker_defines.svh.
`timescale 1ns / 1ps
`include "page_marker_record_walker_defines.svh"

module pmrw_checker import pmrw_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [63:0]        slot_bytes_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [15:0]        page_number_o,
  input logic [7:0]         record_tag_o,
  input logic [7:0]         record_sub_tag_o,
  input logic [15:0]        record_flags_o,
  input logic [7:0]         marker_offset_o,
  input logic [8:0]         payload_offset_o,
  input logic [7:0]         payload_size_o,
  input logic               last_of_page_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [7:0]         cfg_data_i
);

  `PMRW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(record_tag_o) && $stable(marker_offset_o) && $stable(page_number_o) && $stable(last_of_page_o), "output word changed while stalled")

  `PMRW_ASSERT_NOW(a_payload_after_marker, out_valid_o, payload_offset_o[7:0] == 8'(marker_offset_o + 8'd8), "payload offset is not marker offset plus eight")

  `PMRW_ASSERT_NOW(a_slot_aligned, out_valid_o, (marker_offset_o[2:0] == 3'b000) && (payload_size_o[2:0] == 3'b000), "record offset or size not slot aligned")

  `PMRW_ASSERT_NOW(a_marker_tag, out_valid_o, record_tag_o[7:4] == TagLo[7:4], "record tag outside marker range")

endmodule

bind page_marker_record_walker pmrw_checker u_pmrw_checker (.*);

@@ verif/pmrw_record_checker.sv @@
// Record checker for the page marker record walker: watches the slot, record
// and register write channels, predicts the records and compares them.
// Depends on pmrw_pkg for the register indexes, tag constants and record type.
`timescale 1ns / 1ps

module pmrw_record_checker import pmrw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [63:0]        slot_bytes_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [15:0]        page_number_i,
  input  logic [7:0]         record_tag_i,
  input  logic [7:0]         record_sub_tag_i,
  input  logic [15:0]        record_flags_i,
  input  logic [7:0]         marker_offset_i,
  input  logic [8:0]         payload_offset_i,
  input  logic [7:0]         payload_size_i,
  input  logic               last_of_page_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output int                 expected_left_o,
  output int                 mismatch_count_o
);

  localparam int PageBytes    = 256;
  localparam int SlotsPerPage = PageBytes / 8;

  kind_mode_e  kind_mode;
  filter_t     filt;
  logic [4:0]  slot_pos;
  logic        page_ok;
  logic        open_valid;
  logic [7:0]  open_tag;
  logic [7:0]  open_sub_tag;
  logic [15:0] open_flags;
  logic [4:0]  open_slot;
  logic [15:0] page_cnt;
  record_t     record_q[$];
  record_t     step_q[$];
  int          mismatches = 0;
  int          records_seen = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("%0t MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("record %0d %s: got 0x%0h, expected 0x%0h",
                                records_seen, name, got, want));
  endtask

  function automatic logic kind_ok(input logic [7:0] b0);
    case (kind_mode)
      KindLeaf:     return b0 == LeafTag;
      KindInternal: return b0 == InternalTag;
      KindTree:     return (b0 >= TagLo && b0 <= TagHi) || b0 == AltTreeTag;
      default:      return 1'b1;
    endcase
  endfunction

  task automatic close_open_record(input int end_off);
    record_t r;
    int      moff;
    int      poff;
    if (filt.tag != WildFilter && open_tag != filt.tag) return;
    if (filt.sub_tag != WildFilter && open_sub_tag != filt.sub_tag) return;
    moff = int'(open_slot) * 8;
    poff = moff + 8;
    r.page_num = page_cnt;
    r.tag      = open_tag;
    r.sub_tag  = open_sub_tag;
    r.flags    = open_flags;
    r.mark_pos = 8'(moff);
    r.body_pos = 9'(poff);
    r.body_len = (end_off >= poff) ? 8'(end_off - poff) : 8'd0;
    r.last     = 1'b0;
    step_q = {step_q, r};
  endtask

  task automatic walk_slot(input logic [63:0] w);
    logic [7:0] b [8];
    logic       is_marker;
    logic       final_slot;
    record_t    r;
    int         i;
    for (i = 0; i < 8; i++) b[i] = w[63 - 8 * i -: 8];
    final_slot = (int'(slot_pos) == SlotsPerPage - 1);
    step_q.delete();
    if (slot_pos == 5'd0) begin
      page_ok    = kind_ok(b[0]);
      open_valid = 1'b0;
    end
    is_marker = b[0] >= TagLo && b[0] <= TagHi && {b[2], b[3], b[4], b[5]} == MarkerMagic;
    if (page_ok && is_marker) begin
      if (open_valid) close_open_record(int'(slot_pos) * 8);
      open_valid   = 1'b1;
      open_tag     = b[0];
      open_sub_tag = b[1];
      open_flags   = {b[6], b[7]};
      open_slot    = slot_pos;
    end
    if (final_slot) begin
      if (open_valid) close_open_record(PageBytes);
      if (step_q.size() > 0) begin
        r = step_q.pop_back();
        r.last = 1'b1;
        step_q = {step_q, r};
      end
      open_valid = 1'b0;
      page_ok    = 1'b0;
      slot_pos   = 5'd0;
      page_cnt   = page_cnt + 16'd1;
    end else begin
      slot_pos = slot_pos + 5'd1;
    end
    foreach (step_q[k]) record_q = {record_q, step_q[k]};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    record_t got;
    record_t want;
    if (!rst_ni) begin
      kind_mode       = KindAny;
      filt.tag        = WildFilter;
      filt.sub_tag    = WildFilter;
      slot_pos        = 5'd0;
      page_ok         = 1'b0;
      open_valid      = 1'b0;
      open_tag        = 8'd0;
      open_sub_tag    = 8'd0;
      open_flags      = 16'd0;
      open_slot       = 5'd0;
      page_cnt        = 16'd0;
      record_q.delete();
      expected_left_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{page_number_i, record_tag_i, record_sub_tag_i, record_flags_i,
                marker_offset_i, payload_offset_i, payload_size_i, last_of_page_i};
        if (record_q.size() == 0) begin
          report_mismatch($sformatf("record %0d not expected: tag 0x%0h offset %0d",
                                    records_seen, got.tag, got.mark_pos));
        end else begin
          want = record_q.pop_front();
          check_field("page_number", got.page_num, want.page_num);
          check_field("record_tag", got.tag, want.tag);
          check_field("record_sub_tag", got.sub_tag, want.sub_tag);
          check_field("record_flags", got.flags, want.flags);
          check_field("marker_offset", got.mark_pos, want.mark_pos);
          check_field("payload_offset", got.body_pos, want.body_pos);
          check_field("payload size", got.body_len, want.body_len);
          check_field("last_of_page", got.last, want.last);
        end
        records_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegPageKind:     kind_mode = kind_mode_e'(cfg_data_i[1:0]);
          RegTagFilter:    filt.tag = cfg_data_i;
          RegSubTagFilter: filt.sub_tag = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) walk_slot(slot_bytes_i);
      expected_left_o <= record_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the page marker record walker: drives slot words with random
// idling and register writes, and gives the verdict from the checker.
// Depends on pmrw_pkg, page_marker_record_walker and pmrw_record_checker.
`timescale 1ns / 1ps

module tb;
  import pmrw_pkg::*;

  localparam int SlotsPerPage = 32;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [63:0]        slot_bytes_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        page_number_o;
  logic [7:0]         record_tag_o;
  logic [7:0]         record_sub_tag_o;
  logic [15:0]        record_flags_o;
  logic [7:0]         marker_offset_o;
  logic [8:0]         payload_offset_o;
  logic [7:0]         payload_size_o;
  logic               last_of_page_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [7:0]         cfg_data_i = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_cnt = 0;
  int expected_left;
  int mismatch_count;

  page_marker_record_walker DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .slot_bytes_i     (slot_bytes_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .page_number_o    (page_number_o),
    .record_tag_o     (record_tag_o),
    .record_sub_tag_o (record_sub_tag_o),
    .record_flags_o   (record_flags_o),
    .marker_offset_o  (marker_offset_o),
    .payload_offset_o (payload_offset_o),
    .payload_size_o   (payload_size_o),
    .last_of_page_o   (last_of_page_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  pmrw_record_checker u_record_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .slot_bytes_i     (slot_bytes_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .page_number_i    (page_number_o),
    .record_tag_i     (record_tag_o),
    .record_sub_tag_i (record_sub_tag_o),
    .record_flags_i   (record_flags_o),
    .marker_offset_i  (marker_offset_o),
    .payload_offset_i (payload_offset_o),
    .payload_size_i   (payload_size_o),
    .last_of_page_i   (last_of_page_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .expected_left_o  (expected_left),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] marker_word(input logic [7:0] tag, input logic [7:0] sub,
                                              input logic [15:0] flags);
    return {tag, sub, MarkerMagic, flags};
  endfunction

  function automatic logic [7:0] pick_tag();
    case ($urandom_range(4))
      0:       return TagLo;
      1:       return TagHi;
      2:       return LeafTag;
      3:       return InternalTag;
      default: return 8'($urandom_range(TagLo, TagHi));
    endcase
  endfunction

  function automatic logic [7:0] pick_sub_tag();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return WildFilter;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] page_head(input kind_mode_e m);
    if ($urandom_range(99) >= 70) return 8'($urandom);
    case (m)
      KindLeaf:     return LeafTag;
      KindInternal: return InternalTag;
      KindTree:     return $urandom_range(1) ? AltTreeTag : pick_tag();
      default:      return 8'($urandom);
    endcase
  endfunction

  task automatic send_slot(input logic [63:0] w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    slot_bytes_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold the slot channel until every predicted record has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_left != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_setting(input kind_mode_e m, input logic [7:0] tag,
                               input logic [7:0] sub);
    drain();
    write_reg(RegSpare, 8'($urandom));
    write_reg(RegPageKind, {6'($urandom), m});
    write_reg(RegTagFilter, tag);
    write_reg(RegSubTagFilter, sub);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_page(input kind_mode_e m);
    logic [63:0] w;
    int          density;
    int          roll;
    int          s;
    density = $urandom_range(5, 60);
    for (s = 0; s < SlotsPerPage; s++) begin
      roll = $urandom_range(99);
      if (roll < density || (s == SlotsPerPage - 1 && roll < 2 * density)) begin
        w = marker_word(pick_tag(), pick_sub_tag(), 16'($urandom));
      end else if (roll < density + 15) begin
        w = marker_word(pick_tag(), pick_sub_tag(), 16'($urandom));
        if ($urandom_range(1)) w[63:56] = $urandom_range(1) ? TagLo - 8'd1 : TagHi + 8'd1;
        else w[16 + $urandom_range(31)] ^= 1'b1;
      end else begin
        w = {$urandom, $urandom};
      end
      if (s == 0) w[63:56] = page_head(m);
      send_slot(w);
    end
  endtask

  initial begin
    kind_mode_e m;
    logic [7:0] tag;
    logic [7:0] sub;
    int         phase;
    int         k;
    int         s;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 17;
    rx_idle_pct = 45;
    send_slot(marker_word(LeafTag, 8'h00, 16'h0000));
    send_slot(marker_word(TagHi, 8'hFF, 16'hFFFF));
    send_slot(marker_word(TagLo, 8'h01, 16'h8001));
    send_slot('0);
    send_slot('1);
    send_slot({TagLo - 8'd1, 8'h00, MarkerMagic, 16'h1234});
    send_slot({TagHi + 8'd1, 8'h00, MarkerMagic, 16'h1234});
    send_slot({LeafTag, 8'h00, MarkerMagic ^ 32'h0000_0003, 16'h0000});
    send_slot({LeafTag, 8'h00, MarkerMagic | 32'h0100_0000, 16'h0000});
    for (s = 9; s < SlotsPerPage - 2; s++)
      send_slot(s[0] ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555);
    send_slot(marker_word(InternalTag, 8'h5A, 16'h00FF));
    send_slot(marker_word(TagLo, 8'hA5, 16'hFF00));

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 17; rx_idle_pct = 45; end
        1: begin tx_idle_pct = 45; rx_idle_pct = 17; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (k = 0; k < 6; k++) begin
        case (k)
          0: begin m = KindAny; tag = WildFilter; sub = WildFilter; end
          1: begin m = KindLeaf; tag = LeafTag; sub = WildFilter; end
          2: begin m = KindInternal; tag = WildFilter; sub = 8'h00; end
          3: begin m = KindTree; tag = 8'h00; sub = WildFilter; end
          default: begin
            m   = kind_mode_e'($urandom_range(3));
            tag = $urandom_range(1) ? WildFilter : pick_tag();
            sub = $urandom_range(1) ? WildFilter : pick_sub_tag();
          end
        endcase
        apply_setting(m, tag, sub);
        repeat (3) send_page(m);
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
